### rtl/contour_corner_quad_detector_assert.svh
// Assertion helpers for the detector top module.
`ifndef CONTOUR_CORNER_QUAD_DETECTOR_ASSERT_SVH
`define CONTOUR_CORNER_QUAD_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CCQD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CCQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ccqd_pkg.sv
package ccqd_pkg;

  localparam int unsigned QUAD_SIZE = 4;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned MOUND_W   = 32;

  localparam logic [MOUND_W-1:0] THRESH_RESET = 32'h0100_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  // Point after the squaring stage.
  typedef struct packed {
    logic [MOUND_W-1:0] mound;
    pt_t                pt;
    logic               last;
    logic               closed;
  } mound_item_t;

  typedef struct packed {
    logic                     found;
    pt_t [QUAD_SIZE-1:0]      corner;
  } quad_res_t;

  function automatic logic is_peak(input logic [MOUND_W-1:0] mid,
                                   input logic [MOUND_W-1:0] prev,
                                   input logic [MOUND_W-1:0] next,
                                   input logic [MOUND_W-1:0] thr);
    return (mid > prev) && (mid > next) && (mid > thr);
  endfunction

endpackage

### rtl/contour_corner_quad_detector.sv
// An accepted last point reaches out_valid_o via the stage and result registers.
// Throughput: one point per cycle; stalls only while a finished result waits
// and the next last point reaches the corner tracker.
// Stage 1 squares the turn rate, stage 2 runs the peak compares and loads the
// result register. Reset clears the contour counters and valids and loads
// the threshold with 1.0 (Q8.24); the threshold survives contour ends.
`include "contour_corner_quad_detector_assert.svh"

module contour_corner_quad_detector #(
  parameter int unsigned MAX_CORNERS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic               last_point_i,
  input  logic               contour_closed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               quad_found_o,
  output logic signed [15:0] corner0_x_o,
  output logic signed [15:0] corner0_y_o,
  output logic signed [15:0] corner1_x_o,
  output logic signed [15:0] corner1_y_o,
  output logic signed [15:0] corner2_x_o,
  output logic signed [15:0] corner2_y_o,
  output logic signed [15:0] corner3_x_o,
  output logic signed [15:0] corner3_y_o
);

  logic [ccqd_pkg::MOUND_W-1:0] thresh_q;
  logic                         item_valid, take, out_free;
  ccqd_pkg::mound_item_t        item;
  ccqd_pkg::quad_res_t          result, out_q;
  logic                         out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ccqd_pkg::THRESH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thresh_q <= cfg_data_i;
    end
  end

  ccqd_mound_stage u_mound (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .turn_rate_i      (turn_rate_i),
    .last_point_i     (last_point_i),
    .contour_closed_i (contour_closed_i),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_take_i      (take)
  );

  assign out_free = !out_valid_q || out_ready_i;
  // non-last points never touch the result register, so they never wait
  assign take     = item_valid && (!item.last || out_free);

  ccqd_corner_track #(
    .MAX_CORNERS (MAX_CORNERS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thresh_q),
    .item_i      (item),
    .fire_i      (take),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && item.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item.last) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quad_found_o = out_q.found;
  assign corner0_x_o  = out_q.corner[0].x;
  assign corner0_y_o  = out_q.corner[0].y;
  assign corner1_x_o  = out_q.corner[1].x;
  assign corner1_y_o  = out_q.corner[1].y;
  assign corner2_x_o  = out_q.corner[2].x;
  assign corner2_y_o  = out_q.corner[2].y;
  assign corner3_x_o  = out_q.corner[3].x;
  assign corner3_y_o  = out_q.corner[3].y;

  `CCQD_ASSERT_NEXT(a_result_needs_last, out_free && !(take && item.last), !out_valid_q, "result without a last point")

  `CCQD_ASSERT_NOW(a_stall_has_item, !in_ready_o, item_valid && !take, "input stalled with free stage")

  `CCQD_ASSERT_NOW(a_quad_needs_room, out_valid_q && quad_found_o, MAX_CORNERS >= ccqd_pkg::QUAD_SIZE, "quad reported with too few corner slots")

endmodule

### rtl/ccqd_mound_stage.sv
module ccqd_mound_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [15:0]    point_x_i,
  input  logic signed [15:0]    point_y_i,
  input  logic signed [15:0]    turn_rate_i,
  input  logic                  last_point_i,
  input  logic                  contour_closed_i,
  output logic                  item_valid_o,
  output ccqd_pkg::mound_item_t item_o,
  input  logic                  item_take_i
);

  logic                  valid_q, valid_d;
  ccqd_pkg::mound_item_t item_q, item_d;
  logic [15:0]           mag;
  logic                  load;

  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    // |turn_rate|; the most negative code maps to 0x8000, which is exact
    mag = turn_rate_i[15] ? (~turn_rate_i + 16'd1) : turn_rate_i;
    item_d.mound  = {16'd0, mag} * {16'd0, mag};
    item_d.pt.x   = point_x_i;
    item_d.pt.y   = point_y_i;
    item_d.last   = last_point_i;
    item_d.closed = contour_closed_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/ccqd_corner_track.sv
module ccqd_corner_track #(
  parameter int unsigned MAX_CORNERS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ccqd_pkg::MOUND_W-1:0]        threshold_i,
  input  ccqd_pkg::mound_item_t               item_i,
  input  logic                                fire_i,
  output ccqd_pkg::quad_res_t                 result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CORNERS + 1);
  localparam int unsigned QS    = ccqd_pkg::QUAD_SIZE;

  logic [1:0]                      points_seen_q, points_seen_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [ccqd_pkg::MOUND_W-1:0]    first_mound_q, second_mound_q;
  logic [ccqd_pkg::MOUND_W-1:0]    previous_mound_q, pending_mound_q;
  logic [ccqd_pkg::MOUND_W-1:0]    second_new;
  ccqd_pkg::pt_t                   first_pt_q, pending_pt_q;
  ccqd_pkg::pt_t [MAX_CORNERS-1:0] store_q, store_d;
  ccqd_pkg::pt_t [QS-1:0]          ext, shifted;

  logic             ps0, ps1, ps2;
  logic             add_a, add_b, wr_a, wr_b, first_hit, found;
  logic [CNT_W-1:0] count_a, count_b;
  logic [CNT_W:0]   total;

  assign ps0 = (points_seen_q == 2'd0);
  assign ps1 = (points_seen_q == 2'd1);
  assign ps2 = points_seen_q[1];

  always_comb begin
    second_new = ps1 ? item_i.mound : second_mound_q;
    // interior point, judged now that its right neighbor is here
    add_a = ps2 && ccqd_pkg::is_peak(pending_mound_q, previous_mound_q,
                                     item_i.mound, threshold_i);
    // last point wraps to point 0
    add_b = item_i.last && !ps0 &&
            ccqd_pkg::is_peak(item_i.mound, pending_mound_q, first_mound_q, threshold_i);
    // point 0, between the last point and point 1
    first_hit = item_i.last && !ps0 &&
                ccqd_pkg::is_peak(first_mound_q, item_i.mound, second_new, threshold_i);

    wr_a    = add_a && (count_q != CNT_W'(MAX_CORNERS));
    count_a = count_q + CNT_W'(wr_a);
    wr_b    = add_b && (count_a != CNT_W'(MAX_CORNERS));
    count_b = count_a + CNT_W'(wr_b);

    for (int i = 0; i < MAX_CORNERS; i++) begin
      if (wr_a && (count_q == CNT_W'(i))) begin
        store_d[i] = pending_pt_q;
      end else if (wr_b && (count_a == CNT_W'(i))) begin
        store_d[i] = item_i.pt;
      end else begin
        store_d[i] = store_q[i];
      end
    end
  end

  for (genvar k = 0; k < QS; k++) begin : g_ext
    if (k < MAX_CORNERS) begin : g_have
      assign ext[k] = store_d[k];
    end else begin : g_none
      assign ext[k] = '0;
    end
    if (k == 0) begin : g_head
      assign shifted[k] = first_pt_q;
    end else begin : g_tail
      assign shifted[k] = ext[k-1];
    end
  end

  always_comb begin
    total = (CNT_W+1)'(first_hit) + (CNT_W+1)'(count_b);
    found = item_i.closed && (MAX_CORNERS >= QS) && (total >= (CNT_W+1)'(QS));
    result_o.found = found;
    for (int k = 0; k < QS; k++) begin
      if (!found) begin
        result_o.corner[k] = '0;
      end else if (first_hit) begin
        result_o.corner[k] = shifted[k];
      end else begin
        result_o.corner[k] = ext[k];
      end
    end
  end

  always_comb begin
    points_seen_d = points_seen_q;
    count_d       = count_q;
    if (fire_i) begin
      if (item_i.last) begin
        points_seen_d = 2'd0;
        count_d       = '0;
      end else begin
        points_seen_d = ps2 ? points_seen_q : points_seen_q + 2'd1;
        count_d       = count_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_seen_q <= 2'd0;
      count_q       <= '0;
    end else begin
      points_seen_q <= points_seen_d;
      count_q       <= count_d;
    end
  end

  // data side is only read after being written within the same contour
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (ps0) begin
        first_mound_q <= item_i.mound;
        first_pt_q    <= item_i.pt;
      end
      if (ps1) begin
        second_mound_q <= item_i.mound;
      end
      previous_mound_q <= pending_mound_q;
      pending_mound_q  <= item_i.mound;
      pending_pt_q     <= item_i.pt;
      store_q          <= store_d;
    end
  end

endmodule

### test/tb_contour_corner_quad_detector.sv
`timescale 1ns / 100ps

module tb_contour_corner_quad_detector;

  localparam int unsigned CORNER_CAP = 4;
  localparam int RESULT_LATENCY = 2;
  localparam int STALL_LIMIT = 2000;
  localparam int GAP_PCT = 27;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] turn;
  } trace_pt_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] point_x_i;
  logic signed [15:0] point_y_i;
  logic signed [15:0] turn_rate_i;
  logic               last_point_i;
  logic               contour_closed_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               quad_found_o;
  logic signed [15:0] corner0_x_o;
  logic signed [15:0] corner0_y_o;
  logic signed [15:0] corner1_x_o;
  logic signed [15:0] corner1_y_o;
  logic signed [15:0] corner2_x_o;
  logic signed [15:0] corner2_y_o;
  logic signed [15:0] corner3_x_o;
  logic signed [15:0] corner3_y_o;

  contour_corner_quad_detector #(
    .MAX_CORNERS(CORNER_CAP)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .turn_rate_i     (turn_rate_i),
    .last_point_i    (last_point_i),
    .contour_closed_i(contour_closed_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .quad_found_o    (quad_found_o),
    .corner0_x_o     (corner0_x_o),
    .corner0_y_o     (corner0_y_o),
    .corner1_x_o     (corner1_x_o),
    .corner1_y_o     (corner1_y_o),
    .corner2_x_o     (corner2_x_o),
    .corner2_y_o     (corner2_y_o),
    .corner3_x_o     (corner3_x_o),
    .corner3_y_o     (corner3_y_o)
  );

  // Corner tracking state, mirrors the block.
  logic [31:0] mound_limit;
  int          pts_in_contour;
  logic [31:0] mound0, mound1, coords0;
  logic [31:0] mound_prev, mound_last, coords_last;
  logic [31:0] corner_buf [CORNER_CAP];
  int          corner_cnt;

  ccqd_pkg::quad_res_t expected_quads [$];
  trace_pt_t   shape [$];
  int          errors;
  int          idle_cycles;
  bit          send_gaps;
  bit          recv_gaps;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [31:0] mound_of(logic signed [15:0] t);
    logic [15:0] mag;
    mag = t[15] ? 16'(-t) : t;
    return 32'(mag) * 32'(mag);
  endfunction

  function automatic bit peak_over(logic [31:0] mid, logic [31:0] lo_a, logic [31:0] lo_b);
    return (mid > lo_a) && (mid > lo_b) && (mid > mound_limit);
  endfunction

  function automatic void keep_corner(logic [31:0] c);
    if (corner_cnt < CORNER_CAP) begin
      corner_buf[corner_cnt] = c;
      corner_cnt++;
    end
  endfunction

  function automatic void clear_contour();
    pts_in_contour = 0;
    mound0 = '0;
    mound1 = '0;
    coords0 = '0;
    mound_prev = '0;
    mound_last = '0;
    coords_last = '0;
    corner_cnt = 0;
    foreach (corner_buf[i]) corner_buf[i] = '0;
  endfunction

  // A point is judged when its successor arrives; point 0 and the last point
  // are judged at contour end against their wrapped neighbors.
  function automatic void follow_point(trace_pt_t p, bit is_last, bit closed);
    logic [31:0]         m, c;
    logic [31:0]         picks [ccqd_pkg::QUAD_SIZE];
    int                  n, k;
    bit                  lone;
    ccqd_pkg::quad_res_t r;
    m = mound_of(p.turn);
    c = {p.x, p.y};
    n = 0;
    lone = (pts_in_contour == 0);
    if (pts_in_contour == 0) begin
      mound0 = m;
      coords0 = c;
    end else if (pts_in_contour == 1) begin
      mound1 = m;
    end else if (peak_over(mound_last, mound_prev, m)) begin
      keep_corner(coords_last);
    end
    mound_prev = mound_last;
    mound_last = m;
    coords_last = c;
    if (pts_in_contour < 2) pts_in_contour++;
    if (!is_last) return;
    if (!lone) begin
      if (peak_over(m, mound_prev, mound0)) keep_corner(c);
      if (peak_over(mound0, m, mound1)) begin
        picks[n] = coords0;
        n++;
      end
    end
    for (k = 0; k < corner_cnt && n < ccqd_pkg::QUAD_SIZE; k++) begin
      picks[n] = corner_buf[k];
      n++;
    end
    r.found = closed && (n == ccqd_pkg::QUAD_SIZE);
    for (k = 0; k < ccqd_pkg::QUAD_SIZE; k++) r.corner[k] = r.found ? picks[k] : '0;
    expected_quads.push_back(r);
    clear_contour();
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    ccqd_pkg::quad_res_t want, got;
    int k;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.found = quad_found_o;
      got.corner[0] = {corner0_x_o, corner0_y_o};
      got.corner[1] = {corner1_x_o, corner1_y_o};
      got.corner[2] = {corner2_x_o, corner2_y_o};
      got.corner[3] = {corner3_x_o, corner3_y_o};
      if (expected_quads.size() == 0) begin
        $error("quad result with no contour pending");
        errors++;
      end else begin
        want = expected_quads.pop_front();
        check_field("quad_found", 16'(want.found), 16'(got.found));
        for (k = 0; k < ccqd_pkg::QUAD_SIZE; k++) begin
          check_field($sformatf("corner%0d_x", k), want.corner[k].x, got.corner[k].x);
          check_field($sformatf("corner%0d_y", k), want.corner[k].y, got.corner[k].y);
        end
      end
    end
  end

  // Hang detection: cycles with no transaction on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= recv_gaps ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
  end

  task automatic send_point(input trace_pt_t p, input bit is_last, input bit closed);
    while (send_gaps && $urandom_range(99) < GAP_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    point_x_i        <= p.x;
    point_y_i        <= p.y;
    turn_rate_i      <= p.turn;
    last_point_i     <= is_last;
    contour_closed_i <= closed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    follow_point(p, is_last, closed);
    @(negedge clk_i);
  endtask

  task automatic send_shape(input bit closed);
    int i;
    for (i = 0; i < shape.size(); i++) begin
      if (i == shape.size() - 1) send_point(shape[i], 1'b1, closed);
      else send_point(shape[i], 1'b0, 1'($urandom_range(1)));
    end
  endtask

  // Wait until every result is in, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_quads.size() != 0) @(negedge clk_i);
    repeat (RESULT_LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mound_limit = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Coordinates cycle through the extremes.
  function automatic void add_pt(logic signed [15:0] t);
    trace_pt_t p;
    case (shape.size() % 4)
      0: begin p.x = 16'sh7FFF; p.y = 16'sh8000; end
      1: begin p.x = 16'sh8000; p.y = 16'sh7FFF; end
      2: begin p.x = 16'sh0000; p.y = 16'shFFFF; end
      default: begin p.x = 16'shFFFF; p.y = 16'sh0000; end
    endcase
    p.turn = t;
    shape.push_back(p);
  endfunction

  function automatic logic signed [15:0] signed_mag(int mag);
    if ($urandom_range(1)) return 16'(-mag);
    return (mag > 32767) ? 16'sh7FFF : 16'(mag);
  endfunction

  task automatic send_random_contour(output int sent);
    int n, peaks, i, k;
    bit noise;
    trace_pt_t p;
    shape.delete();
    case ($urandom_range(9))
      0:       n = $urandom_range(1, 3);
      1:       n = $urandom_range(15, 40);
      default: n = $urandom_range(4, 14);
    endcase
    noise = ($urandom_range(99) < 20);
    for (i = 0; i < n; i++) begin
      p.x = 16'($urandom);
      p.y = 16'($urandom);
      p.turn = noise ? 16'($urandom) : signed_mag($urandom_range(0, 4000));
      shape.push_back(p);
    end
    if (!noise) begin
      // Mostly spread peaks, so that four-corner contours come up often.
      peaks = ($urandom_range(3) == 0) ? $urandom_range(1, 7) : $urandom_range(3, 5);
      for (k = 0; k < peaks; k++) begin
        i = ((k * n) / peaks + $urandom_range(0, 1)) % n;
        shape[i].turn = signed_mag($urandom_range(3000, 32768));
      end
    end
    send_shape($urandom_range(99) < 85);
    sent = n;
  endtask

  task automatic run_contours(input int target);
    int total, n;
    total = 0;
    while (total < target) begin
      send_random_contour(n);
      total += n;
    end
  endtask

  task automatic test_directed_shapes();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    // single point: its own neighbor, never a corner
    shape.delete();
    add_pt(16'sh8000);
    send_shape(1'b1);
    // two points: each is both neighbors of the other
    shape.delete();
    add_pt(16'sh8000); add_pt(16'sd100);
    send_shape(1'b1);
    // five corners, point 0 among them; first four reported
    shape.delete();
    add_pt(16'sh8000); add_pt(16'sd0); add_pt(16'sd20000); add_pt(16'sd1);
    add_pt(-16'sd20000); add_pt(16'sd0); add_pt(16'sd30000); add_pt(16'sd0);
    add_pt(16'sd25000); add_pt(16'sd0);
    send_shape(1'b1);
    // open contour with four corners, last point one of them
    shape.delete();
    add_pt(16'sd0); add_pt(16'sd20000); add_pt(16'sd0); add_pt(-16'sd20000);
    add_pt(16'sd0); add_pt(16'sd20000); add_pt(16'sd0); add_pt(16'sh7FFF);
    send_shape(1'b0);
  endtask

  task automatic test_threshold_extremes();
    write_threshold(32'h0000_0000);
    run_contours(60);
    write_threshold(32'hFFFF_FFFF);
    run_contours(60);
    write_threshold(32'($urandom_range(0, 32'h4000_0000)));
    run_contours(60);
    write_threshold(ccqd_pkg::THRESH_RESET);
    run_contours(40);
  endtask

  task automatic test_random_contours();
    write_threshold(32'($urandom_range(0, 32'h2000_0000)));
    run_contours(250);
    // long stretch with both sides always ready
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    write_threshold(32'($urandom_range(0, 32'h1000_0000)));
    run_contours(200);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    write_threshold(ccqd_pkg::THRESH_RESET);
    run_contours(200);
    settle();
    run_contours(150);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    point_x_i        = '0;
    point_y_i        = '0;
    turn_rate_i      = '0;
    last_point_i     = 1'b0;
    contour_closed_i = 1'b0;
    out_ready_i      = 1'b0;
    errors           = 0;
    idle_cycles      = 0;
    send_gaps        = 1'b1;
    recv_gaps        = 1'b1;
    mound_limit      = ccqd_pkg::THRESH_RESET;
    clear_contour();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_shapes();
    test_threshold_extremes();
    test_random_contours();
    settle();
    repeat (2 * RESULT_LATENCY + 6) @(negedge clk_i);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
